// ===== sv/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// b64_pkg
// Types, codes and the character classifier shared by the decoder modules.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned ACC_W   = 24;
    localparam int unsigned SEXT_W  = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PAD_W   = 3;
    localparam int unsigned CNT_W   = 2;

    localparam logic [PAD_W-1:0] PAD_MAX     = 3'd4;
    localparam logic [PAD_W-1:0] PAD_NO_DATA = 3'd3;
    localparam logic [CNT_W-1:0] LAST_CHAR   = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_PAD,
        KIND_SPACE,
        KIND_BAD
    } char_kind_t;

    typedef struct packed {
        char_kind_t        kind;
        logic [SEXT_W-1:0] value;
    } char_class_t;

    // one queue entry: a finished group or an error beat
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [1:0]       nbytes;
        logic             err;
    } group_rec_t;

    function automatic char_class_t classify(input logic [BYTE_W-1:0] c);
        char_class_t      res;
        logic [BYTE_W-1:0] diff;
        res.kind  = KIND_BAD;
        res.value = '0;
        diff      = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            diff      = c - 8'h41;
            res.kind  = KIND_DATA;
            res.value = diff[SEXT_W-1:0];
        end else if (c inside {[8'h61:8'h7A]}) begin
            diff      = c - 8'h61 + 8'd26;
            res.kind  = KIND_DATA;
            res.value = diff[SEXT_W-1:0];
        end else if (c inside {[8'h30:8'h39]}) begin
            diff      = c - 8'h30 + 8'd52;
            res.kind  = KIND_DATA;
            res.value = diff[SEXT_W-1:0];
        end else if (c == 8'h2B) begin
            res.kind  = KIND_DATA;
            res.value = 6'd62;
        end else if (c == 8'h2F) begin
            res.kind  = KIND_DATA;
            res.value = 6'd63;
        end else if (c == 8'h3D) begin
            res.kind  = KIND_PAD;
        end else if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
            res.kind  = KIND_SPACE;
        end
        return res;
    endfunction

endpackage

// ===== sv/b64_front.sv =====
// ----------------------------------------------------------------------------
// b64_front
// Accepts characters, classifies them and builds 24-bit groups; pushes
// finished groups and error beats into the queue.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [b64_pkg::BYTE_W-1:0]    s_text_char,
    input  logic                          q_full,
    output logic                          q_push,
    output b64_pkg::group_rec_t           q_rec
);

    logic [b64_pkg::ACC_W-1:0] acc_reg,   acc_next;
    logic [b64_pkg::CNT_W-1:0] chars_reg, chars_next;
    logic [b64_pkg::PAD_W-1:0] pad_reg,   pad_next;

    b64_pkg::char_class_t      cls;
    logic                      accept;
    logic                      counted;
    logic [b64_pkg::ACC_W-1:0] acc_shift;
    logic [b64_pkg::PAD_W-1:0] pad_inc;
    logic [1:0]                nbytes;
    logic                      done;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign cls     = b64_pkg::classify(s_text_char);
    assign counted = (cls.kind == b64_pkg::KIND_DATA) || (cls.kind == b64_pkg::KIND_PAD);
    assign done    = (chars_reg == b64_pkg::LAST_CHAR);

    always_comb begin
        acc_shift = {acc_reg[b64_pkg::ACC_W-b64_pkg::SEXT_W-1:0],
                     (cls.kind == b64_pkg::KIND_PAD) ? 6'd0 : cls.value};
        pad_inc   = pad_reg;
        if (cls.kind == b64_pkg::KIND_PAD && pad_reg != b64_pkg::PAD_MAX) begin
            pad_inc = pad_reg + 3'd1;
        end
        // three or more pads leave nothing to emit
        if (pad_inc >= b64_pkg::PAD_NO_DATA) begin
            nbytes = 2'd0;
        end else begin
            nbytes = 2'd3 - pad_inc[1:0];
        end
    end

    always_comb begin
        acc_next   = acc_reg;
        chars_next = chars_reg;
        pad_next   = pad_reg;
        if (accept && counted) begin
            if (done) begin
                acc_next   = '0;
                chars_next = '0;
                pad_next   = '0;
            end else begin
                acc_next   = acc_shift;
                chars_next = chars_reg + 2'd1;
                pad_next   = pad_inc;
            end
        end
    end

    always_comb begin
        q_push = 1'b0;
        q_rec  = '{acc: acc_shift, nbytes: nbytes, err: 1'b0};
        if (accept) begin
            if (cls.kind == b64_pkg::KIND_BAD) begin
                q_push = 1'b1;
                q_rec  = '{acc: '0, nbytes: 2'd1, err: 1'b1};
            end else if (counted && done && nbytes != 2'd0) begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            chars_reg <= '0;
            pad_reg   <= '0;
        end else begin
            acc_reg   <= acc_next;
            chars_reg <= chars_next;
            pad_reg   <= pad_next;
        end
    end

    // pads in a group can never exceed the group size
    a_pad_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg <= b64_pkg::PAD_MAX)
        else $error("pad count out of range");

    // a pad-only group must not reach the queue
    a_no_empty_group: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && !q_rec.err |-> q_rec.nbytes != 2'd0)
        else $error("empty group pushed");

endmodule

// ===== sv/b64_fifo.sv =====
// ----------------------------------------------------------------------------
// b64_fifo
// Short queue of group records between the front and back parts.
// ----------------------------------------------------------------------------
module b64_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64_pkg::group_rec_t  wr_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 rd_valid,
    output b64_pkg::group_rec_t  rd_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64_pkg::group_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // the front stalls on full, so a push never gets dropped
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== sv/b64_back.sv =====
// ----------------------------------------------------------------------------
// b64_back
// Takes group records from the queue and emits their bytes one beat at a
// time, most significant first, from an output register.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  b64_pkg::group_rec_t         q_rec,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [b64_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                        m_last_of_group,
    output logic                        m_format_error
);

    logic [b64_pkg::ACC_W-1:0] acc_reg,   acc_next;
    logic [1:0]                left_reg,  left_next;
    logic                      err_reg,   err_next;
    logic                      valid_reg, valid_next;
    logic                      beat_done;
    logic                      free;

    assign beat_done = valid_reg && m_ready;
    // output register frees when empty or when its final byte leaves
    assign free      = !valid_reg || (beat_done && left_reg == 2'd1);
    assign q_pop     = free && q_valid;

    always_comb begin
        acc_next   = acc_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        valid_next = valid_reg;
        if (free) begin
            valid_next = q_valid;
            acc_next   = q_rec.acc;
            left_next  = q_rec.nbytes;
            err_next   = q_rec.err;
        end else if (beat_done) begin
            acc_next  = {acc_reg[b64_pkg::ACC_W-b64_pkg::BYTE_W-1:0], 8'd0};
            left_next = left_reg - 2'd1;
        end
    end

    assign m_valid         = valid_reg;
    assign m_data_byte     = acc_reg[b64_pkg::ACC_W-1 -: b64_pkg::BYTE_W];
    assign m_last_of_group = (left_reg == 2'd1);
    assign m_format_error  = err_reg;

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    // an error beat is always a single zero byte marked last
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_format_error |-> m_last_of_group && m_data_byte == '0)
        else $error("malformed error beat");

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> left_reg != 2'd0)
        else $error("valid beat with no bytes left");

endmodule

// ===== sv/base64_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming Base64 text decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// Input channel s_*: one text character per beat (s_text_char). Whitespace is
// dropped silently, '=' counts as a pad, any other non-alphabet byte gives one
// error beat (data 0, last and format_error set) and leaves the group as is.
// Output channel m_*: every fourth counted character yields 3, 2, 1 or 0
// bytes depending on the pad count, most significant first; m_last_of_group
// marks the final byte of the group.
// The edge that accepts the fourth character writes the group to the queue;
// the output register loads it from there once it is free, and the first
// byte is then valid on m_*.
// Throughput: one character per cycle in while the queue has room, and one
// byte per cycle out while m_ready is high; the front part takes a character
// every cycle as long as the group queue (QUEUE_DEPTH records) has room,
// while the back part drains a record one byte at a time, loading the next record as the last byte leaves.
// Reset (aresetn low, synchronous) empties the queue and clears the group.
// When the receiver stalls, the back part holds its beat, the queue fills,
// and s_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module base64_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [b64_pkg::BYTE_W-1:0]  s_text_char,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [b64_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                        m_last_of_group,
    output logic                        m_format_error
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    b64_pkg::group_rec_t  wr_rec;
    b64_pkg::group_rec_t  rd_rec;

    b64_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_char (s_text_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (wr_rec)
    );

    b64_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_rec   (wr_rec),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_rec   (rd_rec)
    );

    b64_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_rec           (rd_rec),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_last_of_group (m_last_of_group),
        .m_format_error  (m_format_error)
    );

endmodule
